/* sv/wavp_pkg.sv */
// ----------------------------------------------------------------------------
// WAV PCM parser package
// Transaction types, tag constants and result codes shared by the parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package wavp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } wav_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [2:0]         error_code;
    logic [15:0]        num_channels;
    logic [31:0]        sample_rate;
    logic [15:0]        bits_per_sample;
    logic [31:0]        data_bytes;
    logic signed [31:0] sample_value;
    logic [15:0]        channel_index;
    logic [31:0]        frame_index;
    logic               last_sample;
  } wav_out_t;

  // Tags as they sit in the shift register after four bytes (first byte lowest)
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_RIFF   = 3'd0;
  localparam logic [2:0] ERR_WAVE   = 3'd1;
  localparam logic [2:0] ERR_FMT    = 3'd2;
  localparam logic [2:0] ERR_DATA   = 3'd3;
  localparam logic [2:0] ERR_FORMAT = 3'd4;

endpackage

`default_nettype wire

/* sv/wavp_core.sv */
// ----------------------------------------------------------------------------
// WAV parser core
// Header checks, field capture and sample assembly, one byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module wavp_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire wavp_pkg::wav_in_t item,
  output logic                  push,
  output wavp_pkg::wav_out_t    push_data
);
  import wavp_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [5:0] OFF_RIFF  = 6'd3;
  localparam logic [5:0] OFF_WAVE  = 6'd11;
  localparam logic [5:0] OFF_FMT   = 6'd15;
  localparam logic [5:0] OFF_CHANS = 6'd23;
  localparam logic [5:0] OFF_RATE  = 6'd27;
  localparam logic [5:0] OFF_BITS  = 6'd35;
  localparam logic [5:0] OFF_DATA  = 6'd39;
  localparam logic [5:0] OFF_LAST  = 6'd43;

  logic [1:0]  phase,     phase_next,     c_phase;
  logic [5:0]  hdr_off,   hdr_off_next,   c_off;
  logic [31:0] shift,     shift_next,     c_shift;
  logic [15:0] chans,     chans_next,     c_chans;
  logic [15:0] bits,      bits_next,      c_bits;
  logic [31:0] rate,      rate_next,      c_rate;
  logic [31:0] remaining, remaining_next, c_rem;
  logic [21:0] frame_bytes, frame_bytes_next, c_fbytes;
  logic [1:0]  seen,      seen_next,      c_seen;
  logic [15:0] chan_now,  chan_now_next,  c_chan;
  logic [31:0] frame_now, frame_now_next, c_frame;

  logic [31:0] sh;
  logic [2:0]  per;
  logic [2:0]  seen_inc;
  logic [31:0] rem_dec;
  logic [15:0] chan_inc;
  logic        bits_ok;
  logic [21:0] fbytes_calc;

  always_comb begin
    // A start byte sees cleared state
    c_phase  = item.start_of_file ? PH_HEADER : phase;
    c_off    = item.start_of_file ? '0 : hdr_off;
    c_shift  = item.start_of_file ? '0 : shift;
    c_chans  = item.start_of_file ? '0 : chans;
    c_bits   = item.start_of_file ? '0 : bits;
    c_rate   = item.start_of_file ? '0 : rate;
    c_rem    = item.start_of_file ? '0 : remaining;
    c_fbytes = item.start_of_file ? '0 : frame_bytes;
    c_seen   = item.start_of_file ? '0 : seen;
    c_chan   = item.start_of_file ? '0 : chan_now;
    c_frame  = item.start_of_file ? '0 : frame_now;

    sh          = {item.data_byte, c_shift[31:8]};
    per         = c_bits[5:3];
    seen_inc    = {1'b0, c_seen} + 3'd1;
    rem_dec     = c_rem - 32'd1;
    chan_inc    = c_chan + 16'd1;
    bits_ok     = (c_bits == 16'd8) || (c_bits == 16'd16) ||
                  (c_bits == 16'd24) || (c_bits == 16'd32);
    fbytes_calc = {6'd0, c_chans} * {19'd0, per};

    phase_next       = c_phase;
    hdr_off_next     = c_off;
    shift_next       = c_shift;
    chans_next       = c_chans;
    bits_next        = c_bits;
    rate_next        = c_rate;
    remaining_next   = c_rem;
    frame_bytes_next = c_fbytes;
    seen_next        = c_seen;
    chan_now_next    = c_chan;
    frame_now_next   = c_frame;
    push             = 1'b0;
    push_data        = '0;

    if (c_phase == PH_HEADER) begin
      shift_next   = sh;
      hdr_off_next = c_off + 6'd1;
      case (c_off)
        OFF_RIFF: begin
          if (sh != TAG_RIFF) begin
            push = 1'b1;
            push_data.result_kind = KIND_ERROR;
            push_data.error_code  = ERR_RIFF;
            phase_next = PH_DONE;
          end
        end
        OFF_WAVE: begin
          if (sh != TAG_WAVE) begin
            push = 1'b1;
            push_data.result_kind = KIND_ERROR;
            push_data.error_code  = ERR_WAVE;
            phase_next = PH_DONE;
          end
        end
        OFF_FMT: begin
          if (sh != TAG_FMT) begin
            push = 1'b1;
            push_data.result_kind = KIND_ERROR;
            push_data.error_code  = ERR_FMT;
            phase_next = PH_DONE;
          end
        end
        OFF_CHANS: chans_next = sh[31:16];
        OFF_RATE:  rate_next  = sh;
        OFF_BITS:  bits_next  = sh[31:16];
        OFF_DATA: begin
          if (sh != TAG_DATA) begin
            push = 1'b1;
            push_data.result_kind = KIND_ERROR;
            push_data.error_code  = ERR_DATA;
            phase_next = PH_DONE;
          end
        end
        OFF_LAST: begin
          remaining_next = sh;
          push = 1'b1;
          if ((c_chans == 16'd0) || !bits_ok) begin
            push_data.result_kind = KIND_ERROR;
            push_data.error_code  = ERR_FORMAT;
            phase_next = PH_DONE;
          end else begin
            frame_bytes_next = fbytes_calc;
            phase_next       = PH_DATA;
            seen_next        = '0;
            chan_now_next    = '0;
            frame_now_next   = '0;
            shift_next       = '0;
            push_data.result_kind     = KIND_HEADER;
            push_data.num_channels    = c_chans;
            push_data.sample_rate     = c_rate;
            push_data.bits_per_sample = c_bits;
            push_data.data_bytes      = sh;
          end
        end
        default: ;
      endcase
    end else if (c_phase == PH_DATA) begin
      if (c_rem == 32'd0) begin
        phase_next = PH_DONE;
      end else if ((c_chan == 16'd0) && (c_seen == 2'd0) &&
                   (c_rem < {10'd0, c_fbytes})) begin
        // drop the trailing partial frame
        phase_next = PH_DONE;
      end else begin
        remaining_next = rem_dec;
        if (seen_inc < per) begin
          seen_next  = seen_inc[1:0];
          shift_next = sh;
        end else begin
          seen_next  = '0;
          shift_next = '0;
          push = 1'b1;
          push_data.result_kind   = KIND_SAMPLE;
          push_data.channel_index = c_chan;
          push_data.frame_index   = c_frame;
          case (per)
            3'd1:    push_data.sample_value = {{24{~sh[31]}}, ~sh[31], sh[30:24]};
            3'd2:    push_data.sample_value = {{16{sh[31]}}, sh[31:16]};
            3'd3:    push_data.sample_value = {{8{sh[31]}}, sh[31:8]};
            default: push_data.sample_value = sh;
          endcase
          chan_now_next = chan_inc;
          if (chan_inc >= c_chans) begin
            chan_now_next  = '0;
            frame_now_next = c_frame + 32'd1;
            push_data.last_sample = (rem_dec < {10'd0, c_fbytes});
          end
        end
      end
    end

    // Hold everything when no transaction
    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      hdr_off     <= '0;
      shift       <= '0;
      chans       <= '0;
      bits        <= '0;
      rate        <= '0;
      remaining   <= '0;
      frame_bytes <= '0;
      seen        <= '0;
      chan_now    <= '0;
      frame_now   <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      hdr_off     <= hdr_off_next;
      shift       <= shift_next;
      chans       <= chans_next;
      bits        <= bits_next;
      rate        <= rate_next;
      remaining   <= remaining_next;
      frame_bytes <= frame_bytes_next;
      seen        <= seen_next;
      chan_now    <= chan_now_next;
      frame_now   <= frame_now_next;
    end
  end

endmodule

`default_nettype wire

/* sv/wavp_out_buf.sv */
// ----------------------------------------------------------------------------
// WAV parser result buffer
// Output register plus one skid entry so the input keeps flowing on a stall until the skid entry is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module wavp_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire wavp_pkg::wav_out_t push_data,
  output logic                    full,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output wavp_pkg::wav_out_t      result
);
  import wavp_pkg::*;

  logic     skid_valid;
  wav_out_t skid;
  logic     head_free;

  assign head_free = !result_valid || result_ready;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (head_free) begin
      result_valid <= skid_valid || push;
      skid_valid   <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid) begin
        result <= skid;
        skid   <= push_data;
      end else begin
        result <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

`default_nettype wire

/* sv/wav_pcm_stream_parser.sv */
// ----------------------------------------------------------------------------
// WAV PCM stream parser
// Checks a 44-byte WAV header and turns the data chunk into PCM samples.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one file byte per transaction; start_of_file marks byte 0
//   of a new file and restarts parsing from the header.
//   result channel: a header result or an error after header byte 43 (or an
//   error at the fourth byte of a bad tag), then one sample result per
//   bits_per_sample/8 data bytes, with channel and frame index.
//   Results are registered in the result register, or in the skid entry first
//   while the result register is held. Throughput: one byte per cycle while
//   item_ready is high; the parser core handles every byte as it is accepted.
//   Stall: a result register plus one skid entry hold results; item_ready
//   drops only while both are occupied.
//   Reset: parser returns to the header phase as if a file starts next;
//   pending results are discarded.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm_stream_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire wavp_pkg::wav_in_t item,
  output logic               result_valid,
  input  wire logic          result_ready,
  output wavp_pkg::wav_out_t result
);
  import wavp_pkg::*;

  logic     accept;
  logic     push;
  logic     full;
  wav_out_t push_data;

  assign item_ready = !full;
  assign accept     = item_valid && item_ready;

  wavp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .push      (push),
    .push_data (push_data)
  );

  wavp_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .full         (full),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

/* bench/wav_pcm_stream_parser_tb.sv */
// ----------------------------------------------------------------------------
// WAV PCM stream parser testbench
// Streams directed and random WAV files through the parser, one byte per
// transaction, with random stalls on both channels. A byte-level decoder in
// the bench predicts every header, error and sample result, and each result
// is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm_stream_parser_tb;
  import wavp_pkg::*;

  localparam int          RAND_ITEMS = 1150;
  localparam int          LIMIT      = 1_500_000;
  localparam int          NUM_CASES  = 14;
  localparam int          TAIL       = 20;
  localparam int          MAX_PRINTS = 40;
  localparam logic [2:0]  NO_ERR     = 3'd0;
  // sample bytes for directed files: extremes of 8, 16 and 32 bit samples
  localparam logic [127:0] DATA_PAT  = 128'h0000_FE01_7FFF_8000_7FFF_FFFF_8000_0000;

  typedef enum logic [1:0] {STG_HEADER, STG_DATA, STG_DONE} stage_e;

  typedef struct packed {
    bit          sof;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] size;
    int          bad_byte;
    int          n_data;
    logic [1:0]  kind;
    logic [2:0]  code;
  } file_case_t;

  logic     clk;
  logic     rst;
  logic     item_valid;
  logic     item_ready;
  wav_in_t  item;
  logic     result_valid;
  logic     result_ready;
  wav_out_t result;

  // decoder state
  stage_e      stage;
  logic [5:0]  hdr_pos;
  logic [31:0] shift_reg;
  logic [15:0] chans_seen;
  logic [15:0] bits_seen;
  logic [31:0] rate_seen;
  logic [31:0] bytes_left;
  logic [21:0] frame_len;
  logic [1:0]  sub_pos;
  logic [15:0] chan_now;
  logic [31:0] frame_now;

  wav_out_t    due_results[$];
  logic [7:0]  hdr_buf [44];
  file_case_t  cases [NUM_CASES];

  int errors;
  int bytes_sent;
  int files_sent;
  int n_headers;
  int n_samples;
  int n_last;
  int n_errors_seen;
  int cycles;
  int rx_hold;
  bit tx_calm;

  wav_pcm_stream_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void restart_parse();
    stage      = STG_HEADER;
    hdr_pos    = '0;
    shift_reg  = '0;
    chans_seen = '0;
    bits_seen  = '0;
    rate_seen  = '0;
    bytes_left = '0;
    frame_len  = '0;
    sub_pos    = '0;
    chan_now   = '0;
    frame_now  = '0;
  endfunction

  function automatic wav_out_t error_result(input logic [2:0] code);
    wav_out_t r;
    r            = '0;
    r.result_kind = KIND_ERROR;
    r.error_code = code;
    stage        = STG_DONE;
    return r;
  endfunction

  // Advance the decoder by one file byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                     output wav_out_t r);
    logic [5:0]  pos;
    logic [31:0] frame_prod;
    logic [31:0] raw;
    logic [31:0] sgn;
    int unsigned per;
    int unsigned seen;
    r = '0;
    if (sof) restart_parse();
    if (stage == STG_HEADER) begin
      shift_reg = {b, shift_reg[31:8]};
      pos       = hdr_pos;
      hdr_pos   = pos + 6'd1;
      case (pos)
        6'd3: if (shift_reg != TAG_RIFF) begin
          r = error_result(ERR_RIFF);
          return 1'b1;
        end
        6'd11: if (shift_reg != TAG_WAVE) begin
          r = error_result(ERR_WAVE);
          return 1'b1;
        end
        6'd15: if (shift_reg != TAG_FMT) begin
          r = error_result(ERR_FMT);
          return 1'b1;
        end
        6'd23: chans_seen = shift_reg[31:16];
        6'd27: rate_seen = shift_reg;
        6'd35: bits_seen = shift_reg[31:16];
        6'd39: if (shift_reg != TAG_DATA) begin
          r = error_result(ERR_DATA);
          return 1'b1;
        end
        6'd43: begin
          bytes_left = shift_reg;
          if (chans_seen == 16'd0 || (bits_seen != 16'd8 && bits_seen != 16'd16 &&
                                      bits_seen != 16'd24 && bits_seen != 16'd32)) begin
            r = error_result(ERR_FORMAT);
            return 1'b1;
          end
          frame_prod      = 32'(chans_seen) * 32'(bits_seen[15:3]);
          frame_len       = frame_prod[21:0];
          stage           = STG_DATA;
          sub_pos         = '0;
          chan_now        = '0;
          frame_now       = '0;
          shift_reg       = '0;
          r.result_kind   = KIND_HEADER;
          r.num_channels  = chans_seen;
          r.sample_rate   = rate_seen;
          r.bits_per_sample = bits_seen;
          r.data_bytes    = bytes_left;
          return 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    end
    if (stage != STG_DATA) return 1'b0;
    // drop the rest once the chunk is used up or only a partial frame remains
    if (bytes_left == 32'd0 ||
        (chan_now == 16'd0 && sub_pos == 2'd0 && bytes_left < 32'(frame_len))) begin
      stage = STG_DONE;
      return 1'b0;
    end
    bytes_left = bytes_left - 32'd1;
    shift_reg  = {b, shift_reg[31:8]};
    per        = bits_seen[5:3];
    seen       = sub_pos + 1;
    if (seen < per) begin
      sub_pos = 2'(seen);
      return 1'b0;
    end
    sub_pos = '0;
    raw = (per >= 4) ? shift_reg : shift_reg >> (8 * (4 - per));
    if (per == 1) begin
      r.sample_value = raw - 32'd128;
    end else if (per >= 4) begin
      r.sample_value = raw;
    end else begin
      sgn            = 32'd1 << (8 * per - 1);
      r.sample_value = (raw ^ sgn) - sgn;
    end
    r.result_kind   = KIND_SAMPLE;
    r.channel_index = chan_now;
    r.frame_index   = frame_now;
    chan_now        = chan_now + 16'd1;
    if (chan_now >= chans_seen) begin
      chan_now  = '0;
      frame_now = frame_now + 32'd1;
      if (bytes_left < 32'(frame_len)) r.last_sample = 1'b1;
    end
    shift_reg = '0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 3))
        0: return 8'h00;
        1: return 8'hFF;
        2: return 8'h80;
        default: return 8'h7F;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Lay out a 44-byte header; bytes outside the checked fields are random.
  task automatic build_header(input logic [15:0] ch, input logic [31:0] rt,
                              input logic [15:0] bt, input logic [31:0] sz,
                              input int bad);
    for (int k = 0; k < 44; k++) hdr_buf[k] = 8'($urandom_range(0, 255));
    for (int k = 0; k < 4; k++) begin
      hdr_buf[k]      = TAG_RIFF[8*k +: 8];
      hdr_buf[8 + k]  = TAG_WAVE[8*k +: 8];
      hdr_buf[12 + k] = TAG_FMT[8*k +: 8];
      hdr_buf[24 + k] = rt[8*k +: 8];
      hdr_buf[36 + k] = TAG_DATA[8*k +: 8];
      hdr_buf[40 + k] = sz[8*k +: 8];
    end
    for (int k = 0; k < 2; k++) begin
      hdr_buf[22 + k] = ch[8*k +: 8];
      hdr_buf[34 + k] = bt[8*k +: 8];
    end
    if (bad >= 0) hdr_buf[bad] = hdr_buf[bad] ^ 8'($urandom_range(1, 255));
  endtask

  // One transaction on the item channel, then predict what it produces.
  task automatic put_byte(input logic [7:0] b, input logic sof, input bit use_want,
                          input wav_out_t want);
    int       gap;
    bit       acc;
    bit       got;
    wav_out_t res;
    wav_in_t  nxt;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    nxt.data_byte     = b;
    nxt.start_of_file = sof;
    item       <= nxt;
    item_valid <= 1'b1;
    do begin
      @(negedge clk);
      acc = item_ready;
      @(posedge clk);
    end while (!acc);
    got = decode_byte(b, sof, res);
    if (use_want) due_results.push_back(want);
    else if (got) due_results.push_back(res);
    bytes_sent++;
  endtask

  task automatic send_file(input bit sof, input int hdr_len, input int n_data,
                           input bit directed, input int want_at, input wav_out_t want);
    for (int k = 0; k < hdr_len; k++)
      put_byte(hdr_buf[k], sof && k == 0, k == want_at, want);
    for (int k = 0; k < n_data; k++)
      put_byte(directed ? DATA_PAT[8*(k % 16) +: 8] : rand_data(), 1'b0, 1'b0, '0);
    files_sent++;
  endtask

  // hold the item channel until the parser has delivered everything owed
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] e,
                             input logic [31:0] a);
    if (e !== a) begin
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, e, a);
    end
  endtask

  task automatic check_result(input wav_out_t got);
    wav_out_t exp;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t: unexpected result: expected none, got kind %0d", $time,
                 got.result_kind);
      return;
    end
    exp = due_results.pop_front();
    check_field("result_kind", 32'(exp.result_kind), 32'(got.result_kind));
    check_field("error_code", 32'(exp.error_code), 32'(got.error_code));
    check_field("num_channels", 32'(exp.num_channels), 32'(got.num_channels));
    check_field("sample_rate", exp.sample_rate, got.sample_rate);
    check_field("bits_per_sample", 32'(exp.bits_per_sample), 32'(got.bits_per_sample));
    check_field("data_bytes", exp.data_bytes, got.data_bytes);
    check_field("sample_value", exp.sample_value, got.sample_value);
    check_field("channel_index", 32'(exp.channel_index), 32'(got.channel_index));
    check_field("frame_index", exp.frame_index, got.frame_index);
    check_field("last_sample", 32'(exp.last_sample), 32'(got.last_sample));
    case (exp.result_kind)
      KIND_HEADER: n_headers++;
      KIND_SAMPLE: n_samples++;
      default:     n_errors_seen++;
    endcase
    if (exp.last_sample) n_last++;
  endtask

  // handshake lines are stable at the falling edge; a hit here is taken at the next rise
  always @(negedge clk) begin
    if (!rst && result_valid && result_ready) check_result(result);
  end

  // result back-pressure: runs of ready broken by stalls, now and then a long one
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (result_ready) begin
      if ($urandom_range(0, 9) < 4) begin
        result_ready <= 1'b0;
        case ($urandom_range(0, 19))
          0:       rx_hold <= $urandom_range(20, 60);
          1, 2, 3,
          4, 5:    rx_hold <= $urandom_range(3, 10);
          default: rx_hold <= $urandom_range(0, 2);
        endcase
      end
    end else begin
      result_ready <= 1'b1;
      rx_hold      <= ($urandom_range(0, 6) == 0) ? $urandom_range(40, 250)
                                                  : $urandom_range(0, 8);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int          at;
    int          sel;
    int          bad;
    int          hlen;
    int          nd;
    int          dir_bytes;
    logic [15:0] ch;
    logic [15:0] bt;
    logic [31:0] sz;
    file_case_t  fc;
    wav_out_t    want;

    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    rx_hold      = 0;
    tx_calm      = 1'b0;
    errors       = 0;
    bytes_sent   = 0;
    files_sent   = 0;
    n_headers    = 0;
    n_samples    = 0;
    n_last       = 0;
    n_errors_seen = 0;
    restart_parse();

    cases = '{
      // no start flag after reset; two bytes past the data chunk
      '{1'b0, 16'd2, 32'd44100, 16'd16, 32'd16, -1, 18, KIND_HEADER, NO_ERR},
      '{1'b1, 16'd2, 32'd44100, 16'd16, 32'd16, 0, 0, KIND_ERROR, ERR_RIFF},
      '{1'b1, 16'd2, 32'd44100, 16'd16, 32'd16, 9, 0, KIND_ERROR, ERR_WAVE},
      '{1'b1, 16'd2, 32'd44100, 16'd16, 32'd16, 15, 0, KIND_ERROR, ERR_FMT},
      '{1'b1, 16'd2, 32'd44100, 16'd16, 32'd16, 38, 0, KIND_ERROR, ERR_DATA},
      // zero channels; the data after it must be ignored
      '{1'b1, 16'd0, 32'd8000, 16'd16, 32'd8, -1, 8, KIND_ERROR, ERR_FORMAT},
      '{1'b1, 16'd1, 32'd8000, 16'd12, 32'd8, -1, 0, KIND_ERROR, ERR_FORMAT},
      '{1'b1, 16'd1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, -1, 0, KIND_ERROR, ERR_FORMAT},
      '{1'b1, 16'd1, 32'd0, 16'd8, 32'd16, -1, 16, KIND_HEADER, NO_ERR},
      // 3 x 24 bit: two whole frames, then two trailing bytes dropped
      '{1'b1, 16'd3, 32'd48000, 16'd24, 32'd20, -1, 22, KIND_HEADER, NO_ERR},
      // widest frame; cut short by the next start flag
      '{1'b1, 16'hFFFF, 32'd96000, 16'd32, 32'hFFFF_FFFF, -1, 8, KIND_HEADER, NO_ERR},
      '{1'b1, 16'd2, 32'd22050, 16'd32, 32'd0, -1, 4, KIND_HEADER, NO_ERR},
      // chunk smaller than a single frame
      '{1'b1, 16'hFFFF, 32'd11025, 16'd8, 32'd100, -1, 4, KIND_HEADER, NO_ERR},
      '{1'b1, 16'd1, 32'h7FFF_FFFF, 16'd32, 32'd16, -1, 16, KIND_HEADER, NO_ERR}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_CASES; i++) begin
      fc   = cases[i];
      build_header(fc.chans, fc.rate, fc.bits, fc.size, fc.bad_byte);
      want = '0;
      want.result_kind = fc.kind;
      if (fc.kind == KIND_ERROR) begin
        want.error_code = fc.code;
        // a bad tag reports at its fourth byte, a bad format at the header end
        at = (fc.code == ERR_FORMAT) ? 43 : (fc.bad_byte | 3);
      end else begin
        want.num_channels    = fc.chans;
        want.sample_rate     = fc.rate;
        want.bits_per_sample = fc.bits;
        want.data_bytes      = fc.size;
        at = 43;
      end
      send_file(fc.sof, 44, fc.n_data, 1'b1, at, want);
    end
    wait_drained();
    dir_bytes = bytes_sent;

    while (bytes_sent < dir_bytes + RAND_ITEMS) begin
      if ($urandom_range(0, 4) == 0) tx_calm = ~tx_calm;
      if ($urandom_range(0, 9) == 0) wait_drained();
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        // noise burst: raw bytes with an occasional start flag
        repeat ($urandom_range(1, 12))
          put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0, '0);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 60)      ch = 16'($urandom_range(1, 2));
        else if (sel < 80) ch = 16'($urandom_range(3, 6));
        else if (sel < 86) ch = 16'd0;
        else if (sel < 93) ch = 16'hFFFF;
        else               ch = 16'($urandom_range(0, 65535));
        bt = ($urandom_range(0, 99) < 85) ? 16'(8 * $urandom_range(1, 4))
                                          : 16'($urandom_range(0, 65535));
        sel = $urandom_range(0, 99);
        if (sel < 75)      sz = 32'($urandom_range(0, 48));
        else if (sel < 85) sz = 32'($urandom_range(49, 400));
        else               sz = $urandom;
        bad = -1;
        if ($urandom_range(0, 9) == 0) begin
          // corrupt one byte of one of the four tags
          sel = $urandom_range(0, 15);
          bad = (sel < 4) ? sel : (sel < 12) ? sel + 4 : sel + 24;
        end
        hlen = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 43) : 44;
        nd   = (sz <= 32'd64) ? int'(sz) + $urandom_range(0, 3) : $urandom_range(0, 64);
        if ($urandom_range(0, 4) == 0) nd = $urandom_range(0, nd);
        if (hlen < 44) nd = 0;
        build_header(ch, $urandom, bt, sz, bad);
        send_file($urandom_range(0, 19) != 0, hlen, nd, 1'b0, -1, '0);
      end
    end

    item_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (TAIL) @(posedge clk);

    $display("Streamed %0d files in %0d bytes: directed tag, format and framing cases,",
             files_sent, bytes_sent);
    $display("then random files and noise; checked %0d headers, %0d samples (%0d last), %0d errors.",
             n_headers, n_samples, n_last, n_errors_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
